// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and codes of the json string unescaper
// Holds the decoder mode type, the status codes and the character entry
// that travels from the decoder through the queue to the byte serializer.
// ----------------------------------------------------------------------------
package jsu_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESCAPE = 3'd1,
		MODE_HEX1   = 3'd2,
		MODE_HEX2   = 3'd3,
		MODE_HEX3   = 3'd4,
		MODE_HEX4   = 3'd5
	} mode_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_BAD_ESCAPE = 3'd1;
	localparam status_t ST_BAD_HEX    = 3'd2;
	localparam status_t ST_CUT_SHORT  = 3'd3;
	localparam status_t ST_TOO_LONG   = 3'd4;

	localparam logic [7:0] CAPACITY_RESET = 8'd128;

	// one decoded character (1 to 3 bytes) or the end-of-string result
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] nbytes;
		logic       is_end;
		status_t    status;
	} entry_t;

endpackage

// File: rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Takes one body byte or end marker per cycle while accept is high, tracks the
// escape mode, checks the output capacity and writes whole characters to the queue.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             accept,
	input  logic             req_type,
	input  logic [7:0]       in_byte,
	output logic             ent_wr,
	output jsu_pkg::entry_t  ent
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	jsu_pkg::mode_t   mode_q, mode_d;
	logic [15:0]      accum_q, accum_d;
	logic [7:0]       count_q, count_d;
	jsu_pkg::status_t err_q, err_d;
	logic [7:0]       cap_q;

	logic [4:0]  hexv;
	logic [15:0] cp;
	logic        emit_req;
	logic [1:0]  emit_n;
	logic [7:0]  eb0, eb1, eb2;
	logic        fits;

	assign hexv = hex_digit(in_byte);
	assign cp   = {accum_q[11:0], hexv[3:0]};
	assign fits = ({1'b0, count_q} + {7'd0, emit_n}) < {1'b0, cap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jsu_pkg::MODE_NORMAL;
			accum_q <= '0;
			count_q <= '0;
			err_q   <= jsu_pkg::ST_OK;
			cap_q   <= jsu_pkg::CAPACITY_RESET;
		end else begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (cfg_wr_en) cap_q <= cfg_wr_data;
		end
	end

	// next mode
	always_comb begin
		mode_d = mode_q;
		if (accept) begin
			if (req_type) begin
				mode_d = jsu_pkg::MODE_NORMAL;
			end else if (err_q == jsu_pkg::ST_OK) begin
				unique case (mode_q)
					jsu_pkg::MODE_ESCAPE: begin
						mode_d = (in_byte == CH_U) ? jsu_pkg::MODE_HEX1 : jsu_pkg::MODE_NORMAL;
					end
					jsu_pkg::MODE_HEX1: mode_d = hexv[4] ? jsu_pkg::MODE_HEX2 : jsu_pkg::MODE_NORMAL;
					jsu_pkg::MODE_HEX2: mode_d = hexv[4] ? jsu_pkg::MODE_HEX3 : jsu_pkg::MODE_NORMAL;
					jsu_pkg::MODE_HEX3: mode_d = hexv[4] ? jsu_pkg::MODE_HEX4 : jsu_pkg::MODE_NORMAL;
					jsu_pkg::MODE_HEX4: mode_d = jsu_pkg::MODE_NORMAL;
					default: begin
						mode_d = (in_byte == CH_BSL) ? jsu_pkg::MODE_ESCAPE : jsu_pkg::MODE_NORMAL;
					end
				endcase
			end
		end
	end

	// datapath and queue write
	always_comb begin
		accum_d  = accum_q;
		count_d  = count_q;
		err_d    = err_q;
		emit_req = 1'b0;
		emit_n   = 2'd1;
		eb0      = 8'd0;
		eb1      = 8'd0;
		eb2      = 8'd0;
		ent      = '0;
		ent_wr   = 1'b0;
		if (accept) begin
			if (req_type) begin
				accum_d    = '0;
				count_d    = '0;
				err_d      = jsu_pkg::ST_OK;
				ent_wr     = 1'b1;
				ent.is_end = 1'b1;
				ent.nbytes = 2'd1;
				ent.status = (err_q == jsu_pkg::ST_OK && mode_q != jsu_pkg::MODE_NORMAL)
					? jsu_pkg::ST_CUT_SHORT : err_q;
			end else if (err_q == jsu_pkg::ST_OK) begin
				unique case (mode_q)
					jsu_pkg::MODE_ESCAPE: begin
						unique case (in_byte) inside
							CH_QUOTE, CH_BSL, CH_SLASH: begin
								emit_req = 1'b1;
								eb0      = in_byte;
							end
							CH_B: begin emit_req = 1'b1; eb0 = 8'h08; end
							CH_F: begin emit_req = 1'b1; eb0 = 8'h0C; end
							CH_N: begin emit_req = 1'b1; eb0 = 8'h0A; end
							CH_R: begin emit_req = 1'b1; eb0 = 8'h0D; end
							CH_T: begin emit_req = 1'b1; eb0 = 8'h09; end
							CH_U: accum_d = '0;
							default: err_d = jsu_pkg::ST_BAD_ESCAPE;
						endcase
					end
					jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
					jsu_pkg::MODE_HEX4: begin
						if (!hexv[4]) begin
							err_d = jsu_pkg::ST_BAD_HEX;
						end else begin
							accum_d = cp;
							if (mode_q == jsu_pkg::MODE_HEX4) begin
								emit_req = 1'b1;
								if (cp < 16'h0080) begin
									eb0 = cp[7:0];
								end else if (cp < 16'h0800) begin
									emit_n = 2'd2;
									eb0    = 8'hC0 | {3'd0, cp[10:6]};
									eb1    = 8'h80 | {2'd0, cp[5:0]};
								end else begin
									emit_n = 2'd3;
									eb0    = 8'hE0 | {4'd0, cp[15:12]};
									eb1    = 8'h80 | {2'd0, cp[11:6]};
									eb2    = 8'h80 | {2'd0, cp[5:0]};
								end
							end
						end
					end
					default: begin
						if (in_byte != CH_BSL) begin
							emit_req = 1'b1;
							eb0      = in_byte;
						end
					end
				endcase
				if (emit_req) begin
					if (fits) begin
						count_d    = count_q + {6'd0, emit_n};
						ent_wr     = 1'b1;
						ent.b0     = eb0;
						ent.b1     = eb1;
						ent.b2     = eb2;
						ent.nbytes = emit_n;
						ent.status = jsu_pkg::ST_OK;
					end else begin
						err_d = jsu_pkg::ST_TOO_LONG;
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo: character queue
// Short register queue between the decoder and the byte serializer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  jsu_pkg::entry_t  wr_data,
	input  logic             rd,
	output jsu_pkg::entry_t  rd_data,
	output logic             full,
	output logic             nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jsu_pkg::entry_t  mem [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) mem[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= ptr_inc(wptr_q);
			if (rd) rptr_q <= ptr_inc(rptr_q);
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("queue written while full");

endmodule

// File: rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: byte serializer
// Holds one character from the queue and presents its bytes one request
// at a time on the result side.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_nonempty,
	input  jsu_pkg::entry_t  q_data,
	output logic             q_rd,
	input  logic             pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             is_end,
	output logic [2:0]       status
);

	logic            valid_q;
	jsu_pkg::entry_t cur_q;
	logic [1:0]      idx_q;
	logic            last;
	logic            take;

	assign empty = !valid_q;
	assign last  = (idx_q == cur_q.nbytes - 2'd1);
	assign take  = pop && valid_q;
	assign q_rd  = q_nonempty && (!valid_q || (take && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (q_rd) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (take) begin
				if (last) valid_q <= 1'b0;
				else idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
	end

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = cur_q.b0;
			2'd1:    out_byte = cur_q.b1;
			default: out_byte = cur_q.b2;
		endcase
	end

	assign is_end = cur_q.is_end;
	assign status = cur_q.status;

	a_end_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && cur_q.is_end |-> cur_q.nbytes == 2'd1 && cur_q.b0 == 8'd0)
		else $error("end result with payload bytes");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q < cur_q.nbytes)
		else $error("byte index past character length");

	a_mid_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last |=> valid_q && $stable(cur_q) && idx_q == $past(idx_q) + 2'd1)
		else $error("character lost before its last byte");

endmodule

// File: rtl/core/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core: json string unescaper with utf-8 output
// Decodes backslash and \u escapes of a json string body, enforces the
// output capacity and reports the first error on the end result.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   --------  -----------------  ---------------------------------
//   input     push / full        req_type, in_byte
//   result    pop / empty        out_byte, is_end, status
//   config    cfg_wr_en          cfg_wr_data (out_capacity)
//
// - one input request per cycle while full is low; a plain or simple-escape byte
//   gives one result, a \u character gives 1 to 3 results, one per cycle at the
//   serializer output port while pop is high
// - a result passes from the edge that accepts its request through the character
//   queue and then the serializer's hold register to the result ports
// - full rises only when the CHAR_FIFO_DEPTH character queue is full, so input
//   keeps flowing while multi-byte characters drain or the result side stalls
// - asynchronous active-low reset; capacity resets to 128, no clearing pass
//
module json_string_unescape_utf8_core #(
	parameter int CHAR_FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input side
	input  logic       push,
	output logic       full,
	input  logic       req_type,
	input  logic [7:0] in_byte,
	// result side
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       is_end,
	output logic [2:0] status,
	// capacity register
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	logic            q_full;
	logic            q_nonempty;
	logic            q_rd;
	logic            ent_wr;
	logic            accept;
	jsu_pkg::entry_t ent;
	jsu_pkg::entry_t q_data;

	// an input request is taken whenever the queue has room
	assign accept = push && !q_full;
	assign full   = q_full;

	// decoder: escape state, hex gathering, capacity check
	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.req_type    (req_type),
		.in_byte     (in_byte),
		.ent_wr      (ent_wr),
		.ent         (ent)
	);

	// whole characters waiting for the serializer
	jsu_fifo #(
		.DEPTH (CHAR_FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (ent_wr),
		.wr_data  (ent),
		.rd       (q_rd),
		.rd_data  (q_data),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	// serializer: one result byte per pop
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.is_end     (is_end),
		.status     (status)
	);

endmodule
